>>> rtl/core/a64rel_pkg.sv
package a64rel_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned AddrW = 64;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_ADRP  = 3'd1,
    CLS_ADR   = 3'd2,
    CLS_B     = 3'd3,
    CLS_BCOND = 3'd4,
    CLS_LDRL  = 3'd5,
    CLS_CB    = 3'd6,
    CLS_TB    = 3'd7
  } cls_e;

  // opcode masks and match values
  localparam logic [WordW-1:0] AdrMask    = 32'h9F00_0000;
  localparam logic [WordW-1:0] AdrpMatch  = 32'h9000_0000;
  localparam logic [WordW-1:0] AdrMatch   = 32'h1000_0000;
  localparam logic [WordW-1:0] BMask      = 32'h7C00_0000;
  localparam logic [WordW-1:0] BMatch     = 32'h1400_0000;
  localparam logic [WordW-1:0] BcondMask  = 32'hFF00_0000;
  localparam logic [WordW-1:0] BcondMatch = 32'h5400_0000;
  localparam logic [WordW-1:0] LdrlMask   = 32'h3F00_0000;
  localparam logic [WordW-1:0] LdrlMatch  = 32'h1800_0000;
  localparam logic [WordW-1:0] CbMask     = 32'h7E00_0000;
  localparam logic [WordW-1:0] CbMatch    = 32'h3400_0000;
  localparam logic [WordW-1:0] TbMatch    = 32'h3600_0000;

  // classified request, held in the queue between front and back
  typedef struct packed {
    logic [WordW-1:0] word;
    cls_e             cls;
    logic [AddrW-1:0] target;
    logic [AddrW-1:0] new_address;
  } entry_t;

endpackage

>>> rtl/core/a64rel_if.sv
interface a64rel_in_if;
  logic                           valid;
  logic                           ready;
  logic [a64rel_pkg::WordW-1:0]   insn_word;
  logic [a64rel_pkg::AddrW-1:0]   old_address;
  logic [a64rel_pkg::AddrW-1:0]   new_address;

  modport source (output valid, output insn_word, output old_address,
                  output new_address, input ready);
  modport sink (input valid, input insn_word, input old_address,
                input new_address, output ready);
endinterface

interface a64rel_out_if;
  logic                           valid;
  logic                           ready;
  logic [a64rel_pkg::WordW-1:0]   out_word;
  logic                           out_of_range;
  logic [2:0]                     insn_class;

  modport source (output valid, output out_word, output out_of_range,
                  output insn_class, input ready);
  modport sink (input valid, input out_word, input out_of_range,
                input insn_class, output ready);
endinterface

>>> rtl/core/a64rel_front.sv
module a64rel_front (
  a64rel_in_if.sink           req_i,
  input  logic                full_i,
  output logic                push_o,
  output a64rel_pkg::entry_t  entry_o
);

  logic [a64rel_pkg::WordW-1:0] w;
  logic [20:0]                  imm21;
  logic [a64rel_pkg::AddrW-1:0] offset;
  logic [a64rel_pkg::AddrW-1:0] sum;
  a64rel_pkg::cls_e             cls;

  assign w     = req_i.insn_word;
  assign imm21 = {w[23:5], w[30:29]};

  always_comb begin
    cls    = a64rel_pkg::CLS_NONE;
    offset = '0;
    if ((w & a64rel_pkg::AdrMask) == a64rel_pkg::AdrpMatch) begin
      cls    = a64rel_pkg::CLS_ADRP;
      offset = {{31{imm21[20]}}, imm21, 12'b0};
    end else if ((w & a64rel_pkg::AdrMask) == a64rel_pkg::AdrMatch) begin
      cls    = a64rel_pkg::CLS_ADR;
      offset = {{43{imm21[20]}}, imm21};
    end else if ((w & a64rel_pkg::BMask) == a64rel_pkg::BMatch) begin
      cls    = a64rel_pkg::CLS_B;
      offset = {{36{w[25]}}, w[25:0], 2'b0};
    end else if ((w & a64rel_pkg::BcondMask) == a64rel_pkg::BcondMatch) begin
      cls    = a64rel_pkg::CLS_BCOND;
      offset = {{43{w[23]}}, w[23:5], 2'b0};
    end else if ((w & a64rel_pkg::LdrlMask) == a64rel_pkg::LdrlMatch) begin
      cls    = a64rel_pkg::CLS_LDRL;
      offset = {{43{w[23]}}, w[23:5], 2'b0};
    end else if ((w & a64rel_pkg::CbMask) == a64rel_pkg::CbMatch) begin
      cls    = a64rel_pkg::CLS_CB;
      offset = {{43{w[23]}}, w[23:5], 2'b0};
    end else if ((w & a64rel_pkg::CbMask) == a64rel_pkg::TbMatch) begin
      cls    = a64rel_pkg::CLS_TB;
      offset = {{48{w[18]}}, w[18:5], 2'b0};
    end
  end

  assign sum = req_i.old_address + offset;

  always_comb begin
    entry_o.word        = w;
    entry_o.cls         = cls;
    entry_o.new_address = req_i.new_address;
    // ADRP targets the page, not the byte
    if (cls == a64rel_pkg::CLS_ADRP) begin
      entry_o.target = {sum[a64rel_pkg::AddrW-1:12], 12'b0};
    end else begin
      entry_o.target = sum;
    end
  end

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

endmodule

>>> rtl/core/a64rel_fifo.sv
module a64rel_fifo #(
  parameter int unsigned Depth = a64rel_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  a64rel_pkg::entry_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output a64rel_pkg::entry_t data_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  a64rel_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/a64rel_back.sv
module a64rel_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  a64rel_pkg::entry_t entry_i,
  input  logic               empty_i,
  output logic               pop_o,
  a64rel_out_if.source       rsp_o
);

  logic [a64rel_pkg::AddrW-1:0] base;
  logic [a64rel_pkg::AddrW-1:0] d;
  logic [a64rel_pkg::WordW-1:0] w;
  logic [a64rel_pkg::WordW-1:0] enc;
  logic                         oor;

  logic                         valid_q, valid_d;
  logic [a64rel_pkg::WordW-1:0] word_q, word_d;
  logic                         oor_q, oor_d;
  logic [2:0]                   cls_q, cls_d;

  assign w = entry_i.word;

  always_comb begin
    if (entry_i.cls == a64rel_pkg::CLS_ADRP) begin
      base = {entry_i.new_address[a64rel_pkg::AddrW-1:12], 12'b0};
    end else begin
      base = entry_i.new_address;
    end
  end

  assign d = entry_i.target - base;

  // range: upper bits are a sign extension; for word-aligned fields the
  // last three unaligned byte offsets below the positive limit are also rejected
  always_comb begin
    oor = 1'b0;
    enc = w;
    case (entry_i.cls)
      a64rel_pkg::CLS_ADRP: begin
        oor = !((d[63:32] == '0) || (d[63:32] == '1));
        enc = {w[31], d[13:12], w[28:24], d[32:14], w[4:0]};
      end
      a64rel_pkg::CLS_ADR: begin
        oor = !((d[63:20] == '0) || (d[63:20] == '1));
        enc = {w[31], d[1:0], w[28:24], d[20:2], w[4:0]};
      end
      a64rel_pkg::CLS_B: begin
        oor = !((d[63:27] == '0) || (d[63:27] == '1))
              || (!d[63] && (&d[26:2]) && (|d[1:0]));
        enc = {w[31:26], d[27:2]};
      end
      a64rel_pkg::CLS_BCOND, a64rel_pkg::CLS_LDRL, a64rel_pkg::CLS_CB: begin
        oor = !((d[63:20] == '0) || (d[63:20] == '1))
              || (!d[63] && (&d[19:2]) && (|d[1:0]));
        enc = {w[31:24], d[20:2], w[4:0]};
      end
      a64rel_pkg::CLS_TB: begin
        oor = !((d[63:15] == '0) || (d[63:15] == '1))
              || (!d[63] && (&d[14:2]) && (|d[1:0]));
        enc = {w[31:19], d[15:2], w[4:0]};
      end
      default: begin
        oor = 1'b0;
        enc = w;
      end
    endcase
  end

  // output register refills from a non-empty queue whenever it is empty or being drained
  assign pop_o = !empty_i && (!valid_q || rsp_o.ready);

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    oor_d   = oor_q;
    cls_d   = cls_q;
    if (pop_o) begin
      valid_d = 1'b1;
      word_d  = oor ? w : enc;
      oor_d   = oor;
      cls_d   = entry_i.cls;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    oor_q  <= oor_d;
    cls_q  <= cls_d;
  end

  assign rsp_o.valid        = valid_q;
  assign rsp_o.out_word     = word_q;
  assign rsp_o.out_of_range = oor_q;
  assign rsp_o.insn_class   = cls_q;

endmodule

>>> rtl/core/arm64_pc_relative_relocator.sv
// Channel | Dir | Payload                                    | Handshake
// req_i   | in  | insn_word, old_address, new_address        | valid/ready
// rsp_o   | out | out_word, out_of_range, insn_class         | valid/ready
//
// One request per cycle while rsp_o.ready is high, via queue and output register.
// Front decodes the class and forms the target with one 64-bit add; back
// subtracts the new address, checks range and re-encodes into an output register.
// The queue between them holds QueueDepth requests, so either side can stall alone.
// Reset clears the queue pointers, count and output valid; no other state.
module arm64_pc_relative_relocator #(
  parameter int unsigned QueueDepth = a64rel_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  a64rel_in_if.sink    req_i,
  a64rel_out_if.source rsp_o
);

  a64rel_pkg::entry_t push_entry;
  a64rel_pkg::entry_t head_entry;
  logic               push, pop, full, empty;

  a64rel_front u_front (
    .req_i   (req_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  a64rel_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_entry),
    .empty_o (empty)
  );

  a64rel_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule
